// ===== rtl/lbc_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU block buffer cache package
// Shared widths, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lbc_pkg;

  localparam int DefEntries = 32;
  localparam int FuncW      = 3;
  localparam int DevW       = 8;
  localparam int BlkW       = 32;
  localparam int IdxW       = 5;
  localparam int KindW      = 2;
  localparam int CntW       = 32;
  localparam int RefW       = 8;
  localparam int InDataW    = 48;
  localparam int OutDataW   = 176;

  // Request functions.
  localparam logic [FuncW-1:0] FN_GET   = 3'd0;
  localparam logic [FuncW-1:0] FN_PUT   = 3'd1;
  localparam logic [FuncW-1:0] FN_SYNC  = 3'd2;
  localparam logic [FuncW-1:0] FN_FLUSH = 3'd3;
  localparam logic [FuncW-1:0] FN_DIRTY = 3'd4;

  // Result kinds.
  localparam logic [KindW-1:0] KD_REPLY = 2'd0;
  localparam logic [KindW-1:0] KD_WRITE = 2'd1;
  localparam logic [KindW-1:0] KD_READ  = 2'd2;

  // Datapath operations.
  localparam logic [3:0] OP_NOP    = 4'd0;
  localparam logic [3:0] OP_LATCH  = 4'd1;
  localparam logic [3:0] OP_INC    = 4'd2;
  localparam logic [3:0] OP_DEC    = 4'd3;
  localparam logic [3:0] OP_TOP    = 4'd4;
  localparam logic [3:0] OP_ZERO   = 4'd5;
  localparam logic [3:0] OP_HIT    = 4'd6;
  localparam logic [3:0] OP_FRONT  = 4'd7;
  localparam logic [3:0] OP_BACK   = 4'd8;
  localparam logic [3:0] OP_VICTIM = 4'd9;
  localparam logic [3:0] OP_FAIL   = 4'd10;
  localparam logic [3:0] OP_PUT    = 4'd11;
  localparam logic [3:0] OP_SYNC   = 4'd12;
  localparam logic [3:0] OP_DIRTY  = 4'd13;
  localparam logic [3:0] OP_FCNT   = 4'd14;
  localparam logic [3:0] OP_FCLR   = 4'd15;

  // Entry field source of an emitted beat.
  localparam logic [1:0] ES_TGT  = 2'd0;
  localparam logic [1:0] ES_IDX  = 2'd1;
  localparam logic [1:0] ES_ZERO = 2'd2;

  typedef struct packed {
    logic [3:0]       op;
    logic             emit;
    logic [KindW-1:0] kind;
    logic [1:0]       esel;
    logic             hit;
    logic             failed;
    logic             last;
  } lbc_cmd_t;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic             idx_ok;
    logic             idx_md;
    logic             look_match;
    logic             flush_match;
    logic             vic_free;
    logic             vic_dirty;
    logic             pos_match;
    logic             ptr_last;
    logic             ptr_zero;
    logic             out_free;
  } lbc_sts_t;

endpackage

// ===== rtl/lru_block_buffer_cache_core.sv =====
// Before the reply beat, a get hit does a tag scan, then a recency search; a get miss
// scans every tag, then searches the recency order from the oldest end for a victim.
// Flush makes a counting pass over the entries, then a pass with a write beat per dirty
// entry of the device; put does a recency search. Output back-pressure stalls each beat.
// Throughput is one request at a time, set by the single sequential entry-scan pointer.
// Reset (rst_n low, synchronous) empties the cache, zeroes the totals, entry i at position i.
// ----------------------------------------------------------------------------
// LRU block buffer cache core
// Tag and replacement-policy manager for a buffer cache, with disk request beats.
// ----------------------------------------------------------------------------
module lru_block_buffer_cache_core #(
  parameter int NUM_ENTRIES = lbc_pkg::DefEntries
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [2:0] func, [10:3] device, [42:11] block_number, [47:43] buffer_index
  input  logic [lbc_pkg::InDataW-1:0]   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [4:0] entry, [12:5] req_device, [44:13] req_block, [45] hit, [46] failed,
  // [78:47] hit_total, [110:79] miss_total, [142:111] read_total,
  // [174:143] write_total, [175] zero
  output logic [lbc_pkg::OutDataW-1:0]  out_tdata,
  // [1:0] kind
  output logic [lbc_pkg::KindW-1:0]     out_tuser,
  output logic                          out_tlast
);

  // The controller walks one pointer over the entries; the datapath holds the tables
  // and a single output register, so a reply may wait while the next request is taken.
  lbc_pkg::lbc_cmd_t cmd;
  lbc_pkg::lbc_sts_t sts;

  lbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lbc_datapath #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/lbc_datapath.sv =====
// ----------------------------------------------------------------------------
// LRU block buffer cache datapath
// Entry tables, recency order, counters, scan pointer and output register.
// ----------------------------------------------------------------------------
module lbc_datapath #(
  parameter int NUM_ENTRIES = lbc_pkg::DefEntries
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lbc_pkg::InDataW-1:0]   in_tdata,
  input  lbc_pkg::lbc_cmd_t             cmd,
  output lbc_pkg::lbc_sts_t             sts,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lbc_pkg::OutDataW-1:0]  out_tdata,
  output logic [lbc_pkg::KindW-1:0]     out_tuser,
  output logic                          out_tlast
);

  localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(NUM_ENTRIES - 1);

  logic [lbc_pkg::FuncW-1:0] func_r;
  logic [lbc_pkg::DevW-1:0]  dev_r;
  logic [lbc_pkg::BlkW-1:0]  blk_r;
  logic [lbc_pkg::IdxW-1:0]  idx_r;
  logic [IW-1:0]             ptr_r;
  logic [IW-1:0]             tgt_r;
  logic [lbc_pkg::DevW-1:0]  old_dev_r;
  logic [lbc_pkg::BlkW-1:0]  old_blk_r;

  logic [lbc_pkg::DevW-1:0]  ent_dev_r  [NUM_ENTRIES];
  logic [lbc_pkg::BlkW-1:0]  ent_blk_r  [NUM_ENTRIES];
  logic [lbc_pkg::RefW-1:0]  ent_refs_r [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0]    mapped_r;
  logic [NUM_ENTRIES-1:0]    dirty_r;
  logic [IW-1:0]             order_r    [NUM_ENTRIES];

  logic [lbc_pkg::CntW-1:0]  hit_cnt_r, miss_cnt_r, read_cnt_r, write_cnt_r;

  logic                          ovalid_r;
  logic [lbc_pkg::OutDataW-1:0]  odata_r;
  logic [lbc_pkg::KindW-1:0]     okind_r;
  logic                          olast_r;

  logic [IW-1:0] cur_v;
  logic [IW-1:0] idx_e;
  logic [IW-1:0] mv_ent;
  logic          idx_ok;
  logic          mv_front, mv_back;
  logic          out_free;
  logic [lbc_pkg::IdxW-1:0] e_entry;
  logic [lbc_pkg::DevW-1:0] e_dev;
  logic [lbc_pkg::BlkW-1:0] e_blk;

  assign cur_v    = order_r[ptr_r];
  assign idx_e    = IW'(idx_r);
  assign idx_ok   = 7'(idx_r) < 7'(NUM_ENTRIES);
  assign out_free = !ovalid_r || out_tready;
  assign mv_front = (cmd.op == lbc_pkg::OP_FRONT) || (cmd.op == lbc_pkg::OP_VICTIM);
  assign mv_back  = (cmd.op == lbc_pkg::OP_BACK);
  assign mv_ent   = (cmd.op == lbc_pkg::OP_VICTIM) ? cur_v : tgt_r;

  always_comb begin
    sts.func        = func_r;
    sts.idx_ok      = idx_ok;
    sts.idx_md      = idx_ok && mapped_r[idx_e] && dirty_r[idx_e];
    sts.look_match  = mapped_r[ptr_r] && (ent_dev_r[ptr_r] == dev_r)
                      && (ent_blk_r[ptr_r] == blk_r);
    sts.flush_match = mapped_r[ptr_r] && dirty_r[ptr_r] && (ent_dev_r[ptr_r] == dev_r);
    sts.vic_free    = (ent_refs_r[cur_v] == '0);
    sts.vic_dirty   = mapped_r[cur_v] && dirty_r[cur_v];
    sts.pos_match   = (cur_v == tgt_r);
    sts.ptr_last    = (ptr_r == LastIdx);
    sts.ptr_zero    = (ptr_r == '0);
    sts.out_free    = out_free;
  end

  // Request latch, scan pointer and saved victim tag.
  always_ff @(posedge clk) begin
    case (cmd.op)
      lbc_pkg::OP_LATCH: begin
        func_r <= in_tdata[2:0];
        dev_r  <= in_tdata[10:3];
        blk_r  <= in_tdata[42:11];
        idx_r  <= in_tdata[47:43];
        ptr_r  <= '0;
      end
      lbc_pkg::OP_INC:  ptr_r <= IW'(ptr_r + 1'b1);
      lbc_pkg::OP_DEC:  ptr_r <= IW'(ptr_r - 1'b1);
      lbc_pkg::OP_TOP:  ptr_r <= LastIdx;
      lbc_pkg::OP_ZERO: ptr_r <= '0;
      lbc_pkg::OP_HIT: begin
        tgt_r <= ptr_r;
        ptr_r <= '0;
      end
      lbc_pkg::OP_VICTIM: begin
        tgt_r     <= cur_v;
        old_dev_r <= ent_dev_r[cur_v];
        old_blk_r <= ent_blk_r[cur_v];
      end
      lbc_pkg::OP_PUT: begin
        tgt_r <= idx_e;
        ptr_r <= '0;
      end
      lbc_pkg::OP_SYNC: begin
        tgt_r     <= idx_e;
        old_dev_r <= ent_dev_r[idx_e];
        old_blk_r <= ent_blk_r[idx_e];
      end
      lbc_pkg::OP_FCNT: ptr_r <= (ptr_r == LastIdx) ? '0 : IW'(ptr_r + 1'b1);
      lbc_pkg::OP_FCLR: begin
        tgt_r     <= ptr_r;
        old_dev_r <= ent_dev_r[ptr_r];
        old_blk_r <= ent_blk_r[ptr_r];
      end
      default: ;
    endcase
  end

  // Tag payload of a newly filled entry.
  always_ff @(posedge clk) begin
    if (cmd.op == lbc_pkg::OP_VICTIM) begin
      ent_dev_r[cur_v] <= dev_r;
      ent_blk_r[cur_v] <= blk_r;
    end
  end

  // Entry status bits and reference counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mapped_r <= '0;
      dirty_r  <= '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        ent_refs_r[i] <= '0;
      end
    end else begin
      case (cmd.op)
        lbc_pkg::OP_HIT: begin
          if (ent_refs_r[ptr_r] != '1) begin
            ent_refs_r[ptr_r] <= ent_refs_r[ptr_r] + 1'b1;
          end
        end
        lbc_pkg::OP_VICTIM: begin
          mapped_r[cur_v]   <= 1'b1;
          dirty_r[cur_v]    <= 1'b0;
          ent_refs_r[cur_v] <= lbc_pkg::RefW'(1);
        end
        lbc_pkg::OP_PUT: begin
          if (ent_refs_r[idx_e] != '0) begin
            ent_refs_r[idx_e] <= ent_refs_r[idx_e] - 1'b1;
          end
        end
        lbc_pkg::OP_SYNC:  dirty_r[idx_e] <= 1'b0;
        lbc_pkg::OP_DIRTY: begin
          if (idx_ok && mapped_r[idx_e]) begin
            dirty_r[idx_e] <= 1'b1;
          end
        end
        lbc_pkg::OP_FCLR:  dirty_r[ptr_r] <= 1'b0;
        default: ;
      endcase
    end
  end

  // Recency order: position 0 is the most recent.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < NUM_ENTRIES; q++) begin
        order_r[q] <= IW'(q);
      end
    end else if (mv_front) begin
      order_r[0] <= mv_ent;
      for (int q = 1; q < NUM_ENTRIES; q++) begin
        if (IW'(q) <= ptr_r) begin
          order_r[q] <= order_r[q-1];
        end
      end
    end else if (mv_back) begin
      for (int q = 0; q < NUM_ENTRIES - 1; q++) begin
        if (IW'(q) >= ptr_r) begin
          order_r[q] <= order_r[q+1];
        end
      end
      order_r[NUM_ENTRIES-1] <= mv_ent;
    end
  end

  // Running totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      read_cnt_r  <= '0;
      write_cnt_r <= '0;
    end else begin
      case (cmd.op)
        lbc_pkg::OP_HIT: hit_cnt_r <= hit_cnt_r + 1'b1;
        lbc_pkg::OP_VICTIM: begin
          miss_cnt_r <= miss_cnt_r + 1'b1;
          read_cnt_r <= read_cnt_r + 1'b1;
          if (sts.vic_dirty) begin
            write_cnt_r <= write_cnt_r + 1'b1;
          end
        end
        lbc_pkg::OP_FAIL: miss_cnt_r  <= miss_cnt_r + 1'b1;
        lbc_pkg::OP_SYNC: write_cnt_r <= write_cnt_r + 1'b1;
        lbc_pkg::OP_FCNT: begin
          if (sts.flush_match) begin
            write_cnt_r <= write_cnt_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register.
  always_comb begin
    case (cmd.esel)
      lbc_pkg::ES_TGT: e_entry = lbc_pkg::IdxW'(tgt_r);
      lbc_pkg::ES_IDX: e_entry = idx_r;
      default:         e_entry = '0;
    endcase
    case (cmd.kind)
      lbc_pkg::KD_WRITE: begin
        e_dev = old_dev_r;
        e_blk = old_blk_r;
      end
      lbc_pkg::KD_READ: begin
        e_dev = dev_r;
        e_blk = blk_r;
      end
      default: begin
        e_dev = '0;
        e_blk = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.emit) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      odata_r <= {1'b0, write_cnt_r, read_cnt_r, miss_cnt_r, hit_cnt_r,
                  cmd.failed, cmd.hit, e_blk, e_dev, e_entry};
      okind_r <= cmd.kind;
      olast_r <= cmd.last;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;

`ifndef SYNTH
  a_dirty_mapped: assert property (@(posedge clk) disable iff (!rst_n)
    (dirty_r & ~mapped_r) == '0)
    else $error("dirty entry that is not mapped");
  a_hit_step: assert property (@(posedge clk) disable iff (!rst_n)
    (hit_cnt_r != $past(hit_cnt_r)) |-> (hit_cnt_r == $past(hit_cnt_r) + 32'd1))
    else $error("hit total moved by more than one");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("result beat overwrote a pending beat");
`endif

endmodule

// ===== rtl/lbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// LRU block buffer cache controller
// Sequences lookups, victim search, flush scans and result beats.
// ----------------------------------------------------------------------------
module lbc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  lbc_pkg::lbc_sts_t sts,
  output lbc_pkg::lbc_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_LOOK  = 4'd2;
  localparam logic [3:0] S_FINDF = 4'd3;
  localparam logic [3:0] S_FINDB = 4'd4;
  localparam logic [3:0] S_VSCAN = 4'd5;
  localparam logic [3:0] S_WREQ  = 4'd6;
  localparam logic [3:0] S_RREQ  = 4'd7;
  localparam logic [3:0] S_FCNT  = 4'd8;
  localparam logic [3:0] S_FEMIT = 4'd9;
  localparam logic [3:0] S_REPLY = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [1:0] rsel_r, rsel_nxt;
  logic       rhit_r, rhit_nxt;
  logic       rfail_r, rfail_nxt;

  always_comb begin
    state_nxt  = state_r;
    rsel_nxt   = rsel_r;
    rhit_nxt   = rhit_r;
    rfail_nxt  = rfail_r;
    in_tready  = 1'b0;
    cmd        = '0;
    cmd.op     = lbc_pkg::OP_NOP;
    cmd.kind   = lbc_pkg::KD_REPLY;
    cmd.esel   = lbc_pkg::ES_TGT;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = lbc_pkg::OP_LATCH;
          rhit_nxt  = 1'b0;
          rfail_nxt = 1'b0;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.func)
          lbc_pkg::FN_GET: state_nxt = S_LOOK;
          lbc_pkg::FN_PUT: begin
            rsel_nxt = lbc_pkg::ES_IDX;
            if (sts.idx_ok) begin
              cmd.op    = lbc_pkg::OP_PUT;
              state_nxt = S_FINDB;
            end else begin
              state_nxt = S_REPLY;
            end
          end
          lbc_pkg::FN_SYNC: begin
            rsel_nxt = lbc_pkg::ES_IDX;
            if (sts.idx_md) begin
              cmd.op    = lbc_pkg::OP_SYNC;
              state_nxt = S_WREQ;
            end else begin
              state_nxt = S_REPLY;
            end
          end
          lbc_pkg::FN_FLUSH: begin
            rsel_nxt  = lbc_pkg::ES_ZERO;
            state_nxt = S_FCNT;
          end
          lbc_pkg::FN_DIRTY: begin
            rsel_nxt  = lbc_pkg::ES_IDX;
            cmd.op    = lbc_pkg::OP_DIRTY;
            state_nxt = S_REPLY;
          end
          default: begin
            rsel_nxt  = lbc_pkg::ES_ZERO;
            state_nxt = S_REPLY;
          end
        endcase
      end
      S_LOOK: begin
        if (sts.look_match) begin
          cmd.op    = lbc_pkg::OP_HIT;
          rsel_nxt  = lbc_pkg::ES_TGT;
          rhit_nxt  = 1'b1;
          state_nxt = S_FINDF;
        end else if (sts.ptr_last) begin
          cmd.op    = lbc_pkg::OP_TOP;
          state_nxt = S_VSCAN;
        end else begin
          cmd.op = lbc_pkg::OP_INC;
        end
      end
      S_FINDF: begin
        if (sts.pos_match) begin
          cmd.op    = lbc_pkg::OP_FRONT;
          state_nxt = S_REPLY;
        end else begin
          cmd.op = lbc_pkg::OP_INC;
        end
      end
      S_FINDB: begin
        if (sts.pos_match) begin
          cmd.op    = lbc_pkg::OP_BACK;
          state_nxt = S_REPLY;
        end else begin
          cmd.op = lbc_pkg::OP_INC;
        end
      end
      S_VSCAN: begin
        if (sts.vic_free) begin
          cmd.op    = lbc_pkg::OP_VICTIM;
          rsel_nxt  = lbc_pkg::ES_TGT;
          state_nxt = sts.vic_dirty ? S_WREQ : S_RREQ;
        end else if (sts.ptr_zero) begin
          cmd.op    = lbc_pkg::OP_FAIL;
          rsel_nxt  = lbc_pkg::ES_ZERO;
          rfail_nxt = 1'b1;
          state_nxt = S_REPLY;
        end else begin
          cmd.op = lbc_pkg::OP_DEC;
        end
      end
      S_WREQ: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = lbc_pkg::KD_WRITE;
          cmd.esel = lbc_pkg::ES_TGT;
          if (sts.func == lbc_pkg::FN_GET) begin
            state_nxt = S_RREQ;
          end else if (sts.func == lbc_pkg::FN_SYNC) begin
            state_nxt = S_REPLY;
          end else if (sts.ptr_last) begin
            state_nxt = S_REPLY;
          end else begin
            cmd.op    = lbc_pkg::OP_INC;
            state_nxt = S_FEMIT;
          end
        end
      end
      S_RREQ: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = lbc_pkg::KD_READ;
          cmd.esel  = lbc_pkg::ES_TGT;
          state_nxt = S_REPLY;
        end
      end
      S_FCNT: begin
        cmd.op = lbc_pkg::OP_FCNT;
        if (sts.ptr_last) begin
          state_nxt = S_FEMIT;
        end
      end
      S_FEMIT: begin
        if (sts.flush_match) begin
          cmd.op    = lbc_pkg::OP_FCLR;
          state_nxt = S_WREQ;
        end else if (sts.ptr_last) begin
          state_nxt = S_REPLY;
        end else begin
          cmd.op = lbc_pkg::OP_INC;
        end
      end
      S_REPLY: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = lbc_pkg::KD_REPLY;
          cmd.esel   = rsel_r;
          cmd.hit    = rhit_r;
          cmd.failed = rfail_r;
          cmd.last   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rsel_r  <= lbc_pkg::ES_ZERO;
      rhit_r  <= 1'b0;
      rfail_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rsel_r  <= rsel_nxt;
      rhit_r  <= rhit_nxt;
      rfail_r <= rfail_nxt;
    end
  end

endmodule

// ===== dv/lru_block_buffer_cache_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU block buffer cache core testbench
// Drives get, put, sync, flush, mark-dirty and unknown requests with random gaps and
// back-pressure, predicts every result beat and compares them in order.
// ----------------------------------------------------------------------------

// Expected result beat.
typedef struct packed {
  logic [1:0]  kind;
  logic [4:0]  entry;
  logic [7:0]  dev;
  logic [31:0] blk;
  logic        hit;
  logic        failed;
  logic        last;
  logic [31:0] hits;
  logic [31:0] misses;
  logic [31:0] reads;
  logic [31:0] writes;
} cache_beat_t;

class cache_scoreboard;
  localparam int N = 32;

  // Shadow copy of the cache tags and policy state.
  logic [7:0]  tag_dev [N];
  logic [31:0] tag_blk [N];
  bit          mapped  [N];
  bit          dirty   [N];
  int          refs    [N];
  int          order   [N];
  logic [31:0] hits, misses, reads, writes;

  cache_beat_t pending[$];
  int errors;
  int beats_checked;

  function new();
    for (int i = 0; i < N; i++) begin
      tag_dev[i] = '0; tag_blk[i] = '0; mapped[i] = 0; dirty[i] = 0;
      refs[i] = 0; order[i] = i;
    end
    hits = 0; misses = 0; reads = 0; writes = 0;
    errors = 0; beats_checked = 0;
  endfunction

  function int position_of(int e);
    for (int p = 0; p < N; p++) if (order[p] == e) return p;
    return N - 1;
  endfunction

  function void to_front(int e);
    int p;
    p = position_of(e);
    for (; p > 0; p--) order[p] = order[p-1];
    order[0] = e;
  endfunction

  function void to_back(int e);
    int p;
    p = position_of(e);
    for (; p + 1 < N; p++) order[p] = order[p+1];
    order[N-1] = e;
  endfunction

  function void add_beat(ref cache_beat_t list[$], input logic [1:0] kind, input int e,
                         input logic [7:0] dev, input logic [31:0] blk,
                         input bit hit, input bit failed);
    cache_beat_t b;
    b = '0;
    b.kind = kind; b.entry = e[4:0]; b.dev = dev; b.blk = blk;
    b.hit = hit; b.failed = failed; b.last = 0;
    list.push_back(b);
  endfunction

  function void lookup_get(ref cache_beat_t list[$], input logic [7:0] dev,
                           input logic [31:0] blk);
    int v;
    for (int i = 0; i < N; i++) begin
      if (mapped[i] && tag_dev[i] == dev && tag_blk[i] == blk) begin
        hits++;
        if (refs[i] < 255) refs[i]++;
        to_front(i);
        add_beat(list, lbc_pkg::KD_REPLY, i, 0, 0, 1, 0);
        return;
      end
    end
    misses++;
    // The victim is the oldest entry with no references.
    for (int p = N - 1; p >= 0; p--) begin
      v = order[p];
      if (refs[v] == 0) begin
        if (mapped[v] && dirty[v]) begin
          writes++;
          add_beat(list, lbc_pkg::KD_WRITE, v, tag_dev[v], tag_blk[v], 0, 0);
        end
        tag_dev[v] = dev; tag_blk[v] = blk; mapped[v] = 1; dirty[v] = 0; refs[v] = 1;
        to_front(v);
        reads++;
        add_beat(list, lbc_pkg::KD_READ, v, dev, blk, 0, 0);
        add_beat(list, lbc_pkg::KD_REPLY, v, 0, 0, 0, 0);
        return;
      end
    end
    add_beat(list, lbc_pkg::KD_REPLY, 0, 0, 0, 0, 1);
  endfunction

  // Notes an accepted request and queues the beats it should produce.
  function void note_request(logic [2:0] func, logic [7:0] dev, logic [31:0] blk,
                             logic [4:0] idx);
    cache_beat_t list[$];
    int i;
    i = idx;
    case (func)
      lbc_pkg::FN_GET: lookup_get(list, dev, blk);
      lbc_pkg::FN_PUT: begin
        if (refs[i] > 0) refs[i]--;
        to_back(i);
        add_beat(list, lbc_pkg::KD_REPLY, i, 0, 0, 0, 0);
      end
      lbc_pkg::FN_SYNC: begin
        if (mapped[i] && dirty[i]) begin
          writes++;
          dirty[i] = 0;
          add_beat(list, lbc_pkg::KD_WRITE, i, tag_dev[i], tag_blk[i], 0, 0);
        end
        add_beat(list, lbc_pkg::KD_REPLY, i, 0, 0, 0, 0);
      end
      lbc_pkg::FN_FLUSH: begin
        for (int e = 0; e < N; e++) begin
          if (mapped[e] && dirty[e] && tag_dev[e] == dev) begin
            writes++;
            dirty[e] = 0;
            add_beat(list, lbc_pkg::KD_WRITE, e, tag_dev[e], tag_blk[e], 0, 0);
          end
        end
        add_beat(list, lbc_pkg::KD_REPLY, 0, 0, 0, 0, 0);
      end
      lbc_pkg::FN_DIRTY: begin
        if (mapped[i]) dirty[i] = 1;
        add_beat(list, lbc_pkg::KD_REPLY, i, 0, 0, 0, 0);
      end
      default: add_beat(list, lbc_pkg::KD_REPLY, 0, 0, 0, 0, 0);
    endcase
    // Every beat carries the totals as they stand after the whole request.
    foreach (list[j]) begin
      list[j].last = (j == list.size() - 1);
      list[j].hits = hits; list[j].misses = misses;
      list[j].reads = reads; list[j].writes = writes;
      pending.push_back(list[j]);
    end
  endfunction

  // Checks one accepted result beat against the oldest expected one.
  function void check_beat(logic [lbc_pkg::OutDataW-1:0] d, logic [1:0] kind, logic last);
    cache_beat_t e;
    cache_beat_t a;
    beats_checked++;
    a.kind = kind; a.entry = d[4:0]; a.dev = d[12:5]; a.blk = d[44:13];
    a.hit = d[45]; a.failed = d[46]; a.last = last;
    a.hits = d[78:47]; a.misses = d[110:79]; a.reads = d[142:111]; a.writes = d[174:143];
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result beat: %p", a);
      return;
    end
    e = pending.pop_front();
    if (a !== e || d[175] !== 1'b0) begin
      errors++;
      if (errors <= 10) $display("mismatch\n  expected %p\n  actual   %p", e, a);
    end
  endfunction
endclass

module lru_block_buffer_cache_core_tb;

  localparam int NumRandom  = 164;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int StallLimit = 2000;

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [lbc_pkg::InDataW-1:0]  in_tdata;
  logic                         out_tvalid;
  logic                         out_tready;
  logic [lbc_pkg::OutDataW-1:0] out_tdata;
  logic [lbc_pkg::KindW-1:0]    out_tuser;
  logic                         out_tlast;

  cache_scoreboard sb;
  int  idle_cycles;
  int  requests_sent;
  // A small pool of block numbers so that gets hit often, plus the extremes.
  logic [31:0] block_pool[8];

  lru_block_buffer_cache_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sends one request beat after a random gap and waits for its acceptance.
  // tvalid is dropped only for a gap, so back-to-back beats keep it high.
  task automatic send_request(logic [2:0] func, logic [7:0] dev, logic [31:0] blk,
                              logic [4:0] idx);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {idx, blk, dev, func};
    do @(posedge clk); while (!in_tready);
    sb.note_request(func, dev, blk, idx);
    requests_sent++;
  endtask

  // A random request with a bias towards gets on a few recurring blocks, so that
  // hits, evictions of dirty victims and failed gets all happen.
  task automatic send_random();
    int pick;
    logic [2:0]  func;
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [4:0]  idx;
    pick = $urandom_range(0, 99);
    dev  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
    blk  = ($urandom_range(0, 9) == 0) ? $urandom : block_pool[$urandom_range(0, 7)];
    idx  = 5'($urandom);
    if (pick < 45)      func = lbc_pkg::FN_GET;
    else if (pick < 70) func = lbc_pkg::FN_PUT;
    else if (pick < 80) func = lbc_pkg::FN_SYNC;
    else if (pick < 85) func = lbc_pkg::FN_FLUSH;
    else if (pick < 97) func = lbc_pkg::FN_DIRTY;
    else                func = 3'($urandom_range(5, 7));
    send_request(func, dev, blk, idx);
  endtask

  // Result side: random back-pressure drawn per beat, checking every accepted beat.
  initial begin
    int hold;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = $urandom_range(0, 4);
      if (hold != 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_beat(out_tdata, out_tuser, out_tlast);
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("timeout: %0d beats still expected", sb.pending.size());
        $display("lru_block_buffer_cache_core_tb failed");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    idle_cycles = 0;
    requests_sent = 0;
    block_pool = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd7, 32'h8000_0000,
                   32'h1234_5678, 32'd42, 32'hAAAA_5555};
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: field extremes, each function and the corner cases.
    send_request(lbc_pkg::FN_GET,   8'd0,  32'd0,         5'd0);   // miss on block zero
    send_request(lbc_pkg::FN_GET,   8'd0,  32'd0,         5'd0);   // hit on the same block
    send_request(lbc_pkg::FN_GET,   8'hFF, 32'hFFFF_FFFF, 5'd31);
    send_request(lbc_pkg::FN_DIRTY, 8'd0,  32'd0,         5'd31);  // mark the oldest-taken entry
    send_request(lbc_pkg::FN_DIRTY, 8'd0,  32'd0,         5'd5);   // unmapped, ignored
    send_request(lbc_pkg::FN_SYNC,  8'd0,  32'd0,         5'd31);  // writes back
    send_request(lbc_pkg::FN_SYNC,  8'd0,  32'd0,         5'd31);  // now clean, reply only
    send_request(lbc_pkg::FN_DIRTY, 8'd0,  32'd0,         5'd31);
    send_request(lbc_pkg::FN_FLUSH, 8'hFF, 32'd0,         5'd0);
    send_request(lbc_pkg::FN_FLUSH, 8'd9,  32'd0,         5'd0);   // nothing to write
    send_request(lbc_pkg::FN_PUT,   8'd0,  32'd0,         5'd10);  // unreferenced entry
    send_request(lbc_pkg::FN_PUT,   8'd0,  32'd0,         5'd31);
    send_request(3'd5,              8'hAA, 32'h5555_AAAA, 5'd21);  // unknown functions
    send_request(3'd7,              8'h55, 32'hAAAA_5555, 5'd10);
    // Fill every entry with a reference so that the last gets fail.
    for (int i = 0; i < 32; i++) send_request(lbc_pkg::FN_GET, 8'd3, 32'(i + 100), 5'd0);
    send_request(lbc_pkg::FN_GET,   8'd4,  32'd1,         5'd0);
    // Release everything again, dirtying half of it on the way.
    for (int i = 0; i < 32; i++) begin
      if (i % 2 == 0) send_request(lbc_pkg::FN_DIRTY, 8'd0, 32'd0, 5'(i));
      send_request(lbc_pkg::FN_PUT, 8'd0, 32'd0, 5'(i));
    end
    send_request(lbc_pkg::FN_FLUSH, 8'd3,  32'd0,         5'd0);

    for (int n = 0; n < NumRandom; n++) send_random();
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("%0d requests sent, %0d result beats checked (%0d hits, %0d misses,",
             requests_sent, sb.beats_checked, sb.hits, sb.misses);
    $display("  %0d reads, %0d writes), %0d mismatches", sb.reads, sb.writes, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("lru_block_buffer_cache_core_tb passed");
    end else begin
      $display("lru_block_buffer_cache_core_tb failed");
    end
    $finish;
  end
endmodule
